/* src/torus_grid_bfs_distance_map_assert.svh */
// Assertion macros shared by the torus grid distance map modules.
`ifndef TORUS_GRID_BFS_DISTANCE_MAP_ASSERT_SVH
`define TORUS_GRID_BFS_DISTANCE_MAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TGBFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGBFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tgbfs_pkg.sv */
// Shared constants and controller/datapath interface types for the grid distance map.
package tgbfs_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;

  localparam int MODE_W  = 2;
  localparam int COORD_W = 5;
  localparam int DIR_W   = 3;

  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

  typedef struct packed {
    logic       in_latch;
    logic       sweep_clr;
    logic       sweep_walls;
    logic       seed;
    logic       pop_rd;
    logic       pop_cap;
    logic       nbr_rd;
    logic       nbr_eval;
    logic       wall_wr;
    logic       q_rd;
    logic [1:0] nbr;
  } tgbfs_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              in_grid;
    logic              sweep_last;
    logic              fifo_empty;
  } tgbfs_stat_t;

endpackage

/* src/tgbfs_ram.sv */
// Generic single write port, single read port RAM with registered read.
module tgbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tgbfs_ctrl.sv */
// Sequencer for wall writes, breadth-first search and neighbor queries.
`include "torus_grid_bfs_distance_map_assert.svh"

module tgbfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output tgbfs_pkg::tgbfs_cmd_t cmd,
  input  tgbfs_pkg::tgbfs_stat_t st
);

  typedef enum logic [3:0] {
    S_CLR_ALL,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_CAPTURE,
    S_NRD,
    S_NEVAL,
    S_QRD,
    S_QWAIT
  } state_t;

  state_t     state;
  logic [1:0] nbr;
  logic       done_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_ALL;
      nbr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_CLR_ALL: begin
          if (st.sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          nbr <= '0;
          case (st.mode)
            tgbfs_pkg::MODE_COMPUTE: state <= S_CLEAR;
            tgbfs_pkg::MODE_QUERY: begin
              if (st.in_grid) begin
                state <= S_QRD;
              end else begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CLEAR: begin
          if (st.sweep_last) begin
            if (st.in_grid) begin
              state <= S_SEED;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SEED: state <= S_POP;
        S_POP: begin
          if (st.fifo_empty) begin
            state <= S_IDLE;
          end else begin
            state <= S_CAPTURE;
          end
        end
        S_CAPTURE: begin
          nbr   <= '0;
          state <= S_NRD;
        end
        S_NRD: state <= S_NEVAL;
        S_NEVAL: begin
          nbr <= nbr + 2'd1;
          if (nbr == 2'd3) begin
            state <= S_POP;
          end else begin
            state <= S_NRD;
          end
        end
        S_QRD: begin
          nbr <= nbr + 2'd1;
          if (nbr == 2'd3) begin
            state <= S_QWAIT;
          end
        end
        S_QWAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // done rises on every transition back to idle from a transaction
  always_comb begin
    case (state)
      S_DECODE: done_next = (st.mode != tgbfs_pkg::MODE_COMPUTE) &&
                            !((st.mode == tgbfs_pkg::MODE_QUERY) && st.in_grid);
      S_CLEAR:  done_next = st.sweep_last && !st.in_grid;
      S_POP:    done_next = st.fifo_empty;
      S_QWAIT:  done_next = 1'b1;
      default:  done_next = 1'b0;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.nbr         = nbr;
    cmd.in_latch    = (state == S_IDLE) && start;
    cmd.sweep_clr   = (state == S_CLR_ALL) || (state == S_CLEAR);
    cmd.sweep_walls = (state == S_CLR_ALL);
    cmd.seed        = (state == S_SEED);
    cmd.pop_rd      = (state == S_POP) && !st.fifo_empty;
    cmd.pop_cap     = (state == S_CAPTURE);
    cmd.nbr_rd      = (state == S_NRD);
    cmd.nbr_eval    = (state == S_NEVAL);
    cmd.q_rd        = (state == S_QRD);
    cmd.wall_wr     = (state == S_DECODE) && (st.mode == tgbfs_pkg::MODE_WRITE);
  end

  `TGBFS_ASSERT_NXT(a_done_pulse, done, !done, "done held for more than one cycle")
  `TGBFS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `TGBFS_ASSERT_IMP(a_done_idle, done, state == S_IDLE, "done outside idle")

endmodule

/* src/tgbfs_dpath.sv */
// Datapath: wall, distance and search queue memories with address and compare logic.
`include "torus_grid_bfs_distance_map_assert.svh"

module tgbfs_dpath #(
  parameter int GRID_ROWS = tgbfs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = tgbfs_pkg::DEF_GRID_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tgbfs_pkg::MODE_W-1:0]      mode,
  input  logic [tgbfs_pkg::COORD_W-1:0]     row,
  input  logic [tgbfs_pkg::COORD_W-1:0]     col,
  input  logic                              is_wall,
  input  logic                              chase,
  output logic [tgbfs_pkg::DIR_W-1:0]       direction,
  input  tgbfs_pkg::tgbfs_cmd_t             cmd,
  output tgbfs_pkg::tgbfs_stat_t            st
);

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  localparam int DW    = AW;
  localparam int DEPTH = 1 << AW;

  // Input transaction fields
  logic [tgbfs_pkg::MODE_W-1:0]  mode_q;
  logic [tgbfs_pkg::COORD_W-1:0] row_q;
  logic [tgbfs_pkg::COORD_W-1:0] col_q;
  logic                          wall_q;
  logic                          chase_q;

  logic [AW-1:0] sweep;
  logic [AW:0]   head;
  logic [AW:0]   tail;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [DW-1:0] cur_dist;
  logic [AW-1:0] nb_addr;

  logic                          q_eval_v;
  logic [1:0]                    q_eval_k;
  logic                          have;
  logic [DW-1:0]                 best_dist;
  logic [tgbfs_pkg::DIR_W-1:0]   best_dir;

  logic          in_grid;
  logic [RW-1:0] src_row;
  logic [CW-1:0] src_col;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] bfs_nb;
  logic [AW-1:0] q_nb;
  logic [DW-1:0] nd;
  logic          push;
  logic          better;

  logic          wall_we;
  logic [AW-1:0] wall_waddr;
  logic          wall_wdata;
  logic          wall_rdata;

  logic          dist_we;
  logic [AW-1:0] dist_waddr;
  logic [DW:0]   dist_wdata;
  logic [AW-1:0] dist_raddr;
  logic [DW:0]   dist_rdata;

  logic          fifo_we;
  logic [AW-1:0] fifo_waddr;
  logic [AW+DW-1:0] fifo_wdata;
  logic [AW+DW-1:0] fifo_rdata;

  function automatic logic [AW-1:0] nbr_addr(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                             input logic [tgbfs_pkg::DIR_W-1:0] d);
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    nr = r;
    nc = c;
    case (d)
      tgbfs_pkg::DIR_UP:    nr = (r == '0) ? RW'(GRID_ROWS - 1) : r - 1'b1;
      tgbfs_pkg::DIR_DOWN:  nr = (r == RW'(GRID_ROWS - 1)) ? '0 : r + 1'b1;
      tgbfs_pkg::DIR_LEFT:  nc = (c == '0) ? CW'(GRID_COLS - 1) : c - 1'b1;
      tgbfs_pkg::DIR_RIGHT: nc = (c == CW'(GRID_COLS - 1)) ? '0 : c + 1'b1;
      default: ;
    endcase
    return {nr, nc};
  endfunction

  // Search expands left, up, right, down
  function automatic logic [tgbfs_pkg::DIR_W-1:0] bfs_dir(input logic [1:0] k);
    logic [tgbfs_pkg::DIR_W-1:0] d;
    case (k)
      2'd0:    d = tgbfs_pkg::DIR_LEFT;
      2'd1:    d = tgbfs_pkg::DIR_UP;
      2'd2:    d = tgbfs_pkg::DIR_RIGHT;
      default: d = tgbfs_pkg::DIR_DOWN;
    endcase
    return d;
  endfunction

  // Query scans up, down, left, right
  function automatic logic [tgbfs_pkg::DIR_W-1:0] query_dir(input logic [1:0] k);
    logic [tgbfs_pkg::DIR_W-1:0] d;
    case (k)
      2'd0:    d = tgbfs_pkg::DIR_UP;
      2'd1:    d = tgbfs_pkg::DIR_DOWN;
      2'd2:    d = tgbfs_pkg::DIR_LEFT;
      default: d = tgbfs_pkg::DIR_RIGHT;
    endcase
    return d;
  endfunction

  assign in_grid  = (int'(row_q) < GRID_ROWS) && (int'(col_q) < GRID_COLS);
  assign src_row  = RW'(row_q);
  assign src_col  = CW'(col_q);
  assign src_addr = {src_row, src_col};
  assign bfs_nb   = nbr_addr(cur_row, cur_col, bfs_dir(cmd.nbr));
  assign q_nb     = nbr_addr(src_row, src_col, query_dir(cmd.nbr));
  assign nd       = cur_dist + 1'b1;
  assign push     = cmd.nbr_eval && !wall_rdata && !dist_rdata[DW];
  assign better   = !have || (chase_q ? (dist_rdata[DW-1:0] < best_dist)
                                      : (dist_rdata[DW-1:0] > best_dist));

  assign st.mode       = mode_q;
  assign st.in_grid    = in_grid;
  assign st.sweep_last = &sweep;
  assign st.fifo_empty = (head == tail);

  assign direction = best_dir;

  // Wall memory
  assign wall_we    = (cmd.sweep_clr && cmd.sweep_walls) || (cmd.wall_wr && in_grid);
  assign wall_waddr = cmd.sweep_clr ? sweep : src_addr;
  assign wall_wdata = cmd.sweep_clr ? 1'b0 : wall_q;

  // Distance memory: {reached, distance}
  assign dist_we    = cmd.sweep_clr || cmd.seed || push;
  assign dist_waddr = cmd.sweep_clr ? sweep : (cmd.seed ? src_addr : nb_addr);
  assign dist_wdata = cmd.sweep_clr ? '0 : (cmd.seed ? {1'b1, DW'(0)} : {1'b1, nd});
  assign dist_raddr = cmd.q_rd ? q_nb : bfs_nb;

  // Search queue: {cell, distance}
  assign fifo_we    = cmd.seed || push;
  assign fifo_waddr = cmd.seed ? '0 : tail[AW-1:0];
  assign fifo_wdata = cmd.seed ? {src_addr, DW'(0)} : {nb_addr, nd};

  always_ff @(posedge clk) begin
    if (cmd.in_latch) begin
      mode_q  <= mode;
      row_q   <= row;
      col_q   <= col;
      wall_q  <= is_wall;
      chase_q <= chase;
    end
    if (cmd.pop_cap) begin
      {cur_row, cur_col, cur_dist} <= fifo_rdata;
    end
    if (cmd.nbr_rd) begin
      nb_addr <= bfs_nb;
    end
    if (q_eval_v && dist_rdata[DW] && better) begin
      best_dist <= dist_rdata[DW-1:0];
    end
    q_eval_k <= cmd.nbr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      head     <= '0;
      tail     <= '0;
      q_eval_v <= 1'b0;
      have     <= 1'b0;
      best_dir <= tgbfs_pkg::DIR_NONE;
    end else begin
      q_eval_v <= cmd.q_rd;
      if (cmd.sweep_clr) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.seed) begin
        head <= '0;
        tail <= (AW + 1)'(1);
      end else begin
        if (cmd.pop_rd) begin
          head <= head + 1'b1;
        end
        if (push) begin
          tail <= tail + 1'b1;
        end
      end
      if (cmd.in_latch) begin
        have     <= 1'b0;
        best_dir <= tgbfs_pkg::DIR_NONE;
      end else if (q_eval_v && dist_rdata[DW] && better) begin
        have     <= 1'b1;
        best_dir <= query_dir(q_eval_k);
      end
    end
  end

  tgbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (bfs_nb),
    .rdata (wall_rdata)
  );

  tgbfs_ram #(.WIDTH(DW + 1), .DEPTH(DEPTH)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  tgbfs_ram #(.WIDTH(AW + DW), .DEPTH(DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head[AW-1:0]),
    .rdata (fifo_rdata)
  );

  `TGBFS_ASSERT_IMP(a_head_le_tail, 1'b1, head <= tail, "queue head passed tail")
  `TGBFS_ASSERT_IMP(a_push_room, push, tail < (AW + 1)'(GRID_ROWS * GRID_COLS), "queue overflow")
  `TGBFS_ASSERT_IMP(a_dir_range, 1'b1, best_dir <= tgbfs_pkg::DIR_RIGHT, "direction code out of range")

endmodule

/* src/torus_grid_bfs_distance_map.sv */
// Top level of the torus grid breadth-first distance map: controller plus datapath.
// Write, unused mode, off-grid query: decode, done on return to idle. In-grid query: decode,
// four neighbor reads, a wait state, done. Compute: clear sweep over N = 2^(rowbits+colbits)
// cells, seed, then per queued cell a pop, capture and four neighbor read/evaluate pairs.
// One transaction in flight; done pulses one cycle and the receiver cannot stall it.
// After rst a clearing pass over all N cells (busy high) opens all walls and marks all unreachable.
module torus_grid_bfs_distance_map #(
  parameter int GRID_ROWS = tgbfs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = tgbfs_pkg::DEF_GRID_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command side: transaction taken when start is high and busy is low
  input  logic                          start,
  output logic                          busy,
  input  logic [tgbfs_pkg::MODE_W-1:0]  mode,
  input  logic [tgbfs_pkg::COORD_W-1:0] row,
  input  logic [tgbfs_pkg::COORD_W-1:0] col,
  input  logic                          is_wall,
  input  logic                          chase,
  // Result side: direction valid in the cycle done is high
  output logic                          done,
  output logic [tgbfs_pkg::DIR_W-1:0]   direction
);

  // Control/status between sequencer and datapath
  tgbfs_pkg::tgbfs_cmd_t  cmd;
  tgbfs_pkg::tgbfs_stat_t st;

  // Sequencer: reset sweep, per-mode flow, search loop over queued cells
  tgbfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  // Datapath: wall map, distance map with reached bit, search queue,
  // torus neighbor addressing and the nearest/farthest compare
  tgbfs_dpath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .is_wall   (is_wall),
    .chase     (chase),
    .direction (direction),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* tb/tb_torus_grid_bfs_distance_map.sv */
// Self-checking testbench for the torus grid breadth-first distance map.
module tb_torus_grid_bfs_distance_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS  = tgbfs_pkg::DEF_GRID_ROWS;
  localparam int COLS  = tgbfs_pkg::DEF_GRID_COLS;
  localparam int CELLS = ROWS * COLS;

  // Mode 3 is not decoded by the block: no state change, direction none.
  localparam logic [tgbfs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1550;
  localparam int MAX_GAP      = 17;
  // Longest quiet stretch of a correct run is one compute over an open grid:
  // the clear sweep, the seed and a pop plus four neighbor steps per cell; the limit lies above it.
  localparam int STALL_LIMIT  = 60000;
  // Longest non-compute transaction is an in-grid query; give a little margin at the end.
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [tgbfs_pkg::MODE_W-1:0]  mode;
    logic [tgbfs_pkg::COORD_W-1:0] row;
    logic [tgbfs_pkg::COORD_W-1:0] col;
    logic                          is_wall;
    logic                          chase;
    int unsigned                   gap;    // idle cycles before this transaction is offered
  } grid_cmd_t;

  // DUT inputs are known from time zero.
  logic                          clk     = 1'b0;
  logic                          rst     = 1'b1;
  logic                          start   = 1'b0;
  logic [tgbfs_pkg::MODE_W-1:0]  mode    = tgbfs_pkg::MODE_WRITE;
  logic [tgbfs_pkg::COORD_W-1:0] row     = '0;
  logic [tgbfs_pkg::COORD_W-1:0] col     = '0;
  logic                          is_wall = 1'b0;
  logic                          chase   = 1'b0;
  logic                          busy;
  logic                          done;
  logic [tgbfs_pkg::DIR_W-1:0]   direction;

  torus_grid_bfs_distance_map DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .is_wall   (is_wall),
    .chase     (chase),
    .done      (done),
    .direction (direction)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the grid state. Reset: every cell open, nothing reached.
  // ---------------------------------------------------------------------------
  bit          wall_bits    [CELLS];
  bit          reached_bits [CELLS];
  int unsigned hop_count    [CELLS];
  int unsigned bfs_fifo     [CELLS];
  int unsigned bfs_tail;

  grid_cmd_t                   cmd_backlog[$];    // transactions not yet offered
  logic [tgbfs_pkg::DIR_W-1:0] expected_dirs[$];  // one per accepted transaction, in order
  int unsigned      error_count   = 0;
  int unsigned      result_count  = 0;
  int unsigned      useful_count  = 0; // items the block does not ignore
  int unsigned      calm_left     = 0; // items left in a no-idle stretch

  // Torus neighbors
  function automatic int unsigned row_up(int unsigned r);
    return (r == 0) ? ROWS - 1 : r - 1;
  endfunction

  function automatic int unsigned row_down(int unsigned r);
    return (r + 1 >= ROWS) ? 0 : r + 1;
  endfunction

  function automatic int unsigned col_left(int unsigned c);
    return (c == 0) ? COLS - 1 : c - 1;
  endfunction

  function automatic int unsigned col_right(int unsigned c);
    return (c + 1 >= COLS) ? 0 : c + 1;
  endfunction

  function automatic int unsigned cell_index(int unsigned r, int unsigned c);
    return r * COLS + c;
  endfunction

  // Marked on push, so a cell enters the search FIFO once at most.
  function automatic void push_cell(int unsigned idx, int unsigned hops);
    if (reached_bits[idx] || wall_bits[idx]) return;
    reached_bits[idx]  = 1'b1;
    hop_count[idx]     = hops;
    bfs_fifo[bfs_tail] = idx;
    bfs_tail++;
  endfunction

  // Applies one transaction to the shadow state and returns its direction.
  function automatic logic [tgbfs_pkg::DIR_W-1:0] predict_direction(
    input logic [tgbfs_pkg::MODE_W-1:0]  m,
    input logic [tgbfs_pkg::COORD_W-1:0] r,
    input logic [tgbfs_pkg::COORD_W-1:0] c,
    input logic                          w,
    input logic                          near
  );
    int unsigned                 src, head, idx, pr, pc, nd, best_d;
    int unsigned                 cand [4];
    logic [tgbfs_pkg::DIR_W-1:0] dirs [4];
    logic [tgbfs_pkg::DIR_W-1:0] best;
    bit                          have;
    best   = tgbfs_pkg::DIR_NONE;
    have   = 1'b0;
    best_d = 0;
    case (m)
      tgbfs_pkg::MODE_WRITE: wall_bits[cell_index(r, c)] = w;
      tgbfs_pkg::MODE_COMPUTE: begin
        for (int i = 0; i < CELLS; i++) begin
          reached_bits[i] = 1'b0;
          hop_count[i]    = 0;
        end
        // Source gets distance 0 even when it sits on a wall.
        src               = cell_index(r, c);
        reached_bits[src] = 1'b1;
        hop_count[src]    = 0;
        bfs_fifo[0]       = src;
        bfs_tail          = 1;
        head              = 0;
        while (head < bfs_tail) begin
          idx = bfs_fifo[head];
          head++;
          pr = idx / COLS;
          pc = idx % COLS;
          nd = hop_count[idx] + 1;
          push_cell(cell_index(pr, col_left(pc)), nd);
          push_cell(cell_index(row_up(pr), pc), nd);
          push_cell(cell_index(pr, col_right(pc)), nd);
          push_cell(cell_index(row_down(pr), pc), nd);
        end
      end
      tgbfs_pkg::MODE_QUERY: begin
        cand[0] = cell_index(row_up(r), c);
        cand[1] = cell_index(row_down(r), c);
        cand[2] = cell_index(r, col_left(c));
        cand[3] = cell_index(r, col_right(c));
        dirs[0] = tgbfs_pkg::DIR_UP;
        dirs[1] = tgbfs_pkg::DIR_DOWN;
        dirs[2] = tgbfs_pkg::DIR_LEFT;
        dirs[3] = tgbfs_pkg::DIR_RIGHT;
        // Strict compare: the first neighbor in up/down/left/right order keeps a tie.
        for (int k = 0; k < 4; k++) begin
          if (reached_bits[cand[k]]) begin
            if (!have || (near ? hop_count[cand[k]] < best_d
                               : hop_count[cand[k]] > best_d)) begin
              have   = 1'b1;
              best_d = hop_count[cand[k]];
              best   = dirs[k];
            end
          end
        end
      end
      default: ;
    endcase
    return best;
  endfunction

  // Queues one transaction with its idle gap. Gaps are 0..17, with occasional
  // stretches of back-to-back traffic.
  task automatic add_cmd(input logic [tgbfs_pkg::MODE_W-1:0] m, input int unsigned r,
                         input int unsigned c, input bit w, input bit near);
    grid_cmd_t cmd;
    cmd.mode    = m;
    cmd.row     = r[tgbfs_pkg::COORD_W-1:0];
    cmd.col     = c[tgbfs_pkg::COORD_W-1:0];
    cmd.is_wall = w;
    cmd.chase   = near;
    if (calm_left > 0) begin
      cmd.gap = 0;
      calm_left--;
    end else begin
      cmd.gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(8, 40);
    end
    if (m != MODE_UNUSED) useful_count++;
    cmd_backlog.push_back(cmd);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog one transaction at a time. A transaction is
  // taken at an edge with start high and busy low; start is only lowered when
  // the next one has a nonzero gap or none remains, so it never toggles in one step.
  // ---------------------------------------------------------------------------
  task automatic present(input grid_cmd_t cmd);
    mode    <= cmd.mode;
    row     <= cmd.row;
    col     <= cmd.col;
    is_wall <= cmd.is_wall;
    chase   <= cmd.chase;
  endtask

  int unsigned hold_cycles = 0;

  always @(posedge clk) begin : driver
    grid_cmd_t nxt;
    if (rst) begin
      start       <= 1'b0;
      hold_cycles = 0;
    end else if (start && !busy) begin
      // Predict from the very values the DUT samples at this edge.
      expected_dirs.push_back(predict_direction(mode, row, col, is_wall, chase));
      if (cmd_backlog.size() > 0 && cmd_backlog[0].gap == 0) begin
        nxt = cmd_backlog.pop_front();
        present(nxt);
      end else begin
        start <= 1'b0;
        hold_cycles = (cmd_backlog.size() > 0) ? cmd_backlog[0].gap - 1 : 0;
      end
    end else if (!start) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        present(nxt);
        start <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done is a one-cycle strobe, the result is taken at the edge that
  // ends it and matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [tgbfs_pkg::DIR_W-1:0] want;
    if (!rst && done) begin
      if (expected_dirs.size() == 0) begin
        report_mismatch($sformatf("direction %0d with no transaction pending", direction));
      end else begin
        want = expected_dirs.pop_front();
        if (direction !== want)
          report_mismatch($sformatf("direction got %0d expected %0d", direction, want));
      end
      result_count++;
    end
  end

  // Watchdog: too long without any transaction or result ends the run.
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** torus_grid_bfs_distance_map: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind, n, density, line, holes, hole_a, hole_b, pick;
    bit          horiz;

    // Directed part. Nothing reached yet: a query finds no candidate.
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 0, 1'b0, 1'b1);
    add_cmd(MODE_UNUSED, 31, 31, 1'b1, 1'b1);
    // Open grid from the corner: every cell reached, wraparound on all edges.
    add_cmd(tgbfs_pkg::MODE_COMPUTE, 0, 0, 1'b0, 1'b0);
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 0, 1'b0, 1'b1);    // four-way tie, up wins
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 0, 1'b1, 1'b0);
    add_cmd(tgbfs_pkg::MODE_QUERY, 31, 31, 1'b0, 1'b1);  // nearest through the wrap
    add_cmd(tgbfs_pkg::MODE_QUERY, 31, 31, 1'b1, 1'b0);  // farthest
    add_cmd(tgbfs_pkg::MODE_QUERY, 16, 16, 1'b0, 1'b0);  // farthest cell of the torus
    // Source on a wall, plus a cell boxed in by four walls.
    add_cmd(tgbfs_pkg::MODE_WRITE, 0, 0, 1'b1, 1'b0);
    add_cmd(tgbfs_pkg::MODE_WRITE, 4, 5, 1'b1, 1'b1);
    add_cmd(tgbfs_pkg::MODE_WRITE, 6, 5, 1'b1, 1'b0);
    add_cmd(tgbfs_pkg::MODE_WRITE, 5, 4, 1'b1, 1'b1);
    add_cmd(tgbfs_pkg::MODE_WRITE, 5, 6, 1'b1, 1'b0);
    add_cmd(tgbfs_pkg::MODE_COMPUTE, 0, 0, 1'b0, 1'b1);
    add_cmd(tgbfs_pkg::MODE_QUERY, 5, 5, 1'b0, 1'b1);    // no reachable neighbor
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 1, 1'b0, 1'b1);    // walled source still at distance 0
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 1, 1'b0, 1'b0);
    // Search that starts inside the box reaches only its source.
    add_cmd(tgbfs_pkg::MODE_COMPUTE, 5, 5, 1'b1, 1'b0);
    add_cmd(tgbfs_pkg::MODE_QUERY, 5, 4, 1'b0, 1'b0);    // queried cell is itself a wall
    add_cmd(tgbfs_pkg::MODE_QUERY, 0, 1, 1'b1, 1'b1);
    add_cmd(tgbfs_pkg::MODE_WRITE, 0, 0, 1'b0, 1'b1);
    add_cmd(tgbfs_pkg::MODE_WRITE, 4, 5, 1'b0, 1'b0);
    add_cmd(tgbfs_pkg::MODE_WRITE, 6, 5, 1'b0, 1'b1);
    add_cmd(tgbfs_pkg::MODE_WRITE, 5, 4, 1'b0, 1'b0);
    add_cmd(tgbfs_pkg::MODE_WRITE, 5, 6, 1'b0, 1'b1);

    // Random part, in episodes: reshape the walls, search, then query a lot.
    useful_count = 0;
    while (useful_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        n       = $urandom_range(0, 40);
        density = $urandom_range(0, 60);
        repeat (n)
          add_cmd(tgbfs_pkg::MODE_WRITE, $urandom_range(0, ROWS - 1),
                  $urandom_range(0, COLS - 1),
                  $urandom_range(0, 99) < density, $urandom_range(0, 1));
      end else begin
        // Full wall line with up to two holes forces long detours; kind 9 reopens one.
        horiz  = $urandom_range(0, 1);
        line   = $urandom_range(0, ROWS - 1);
        holes  = $urandom_range(0, 2);
        hole_a = $urandom_range(0, COLS - 1);
        hole_b = $urandom_range(0, COLS - 1);
        for (int i = 0; i < COLS; i++) begin
          bit w;
          w = (kind < 9) && !((holes > 0 && i == hole_a) || (holes > 1 && i == hole_b));
          if (horiz) add_cmd(tgbfs_pkg::MODE_WRITE, line, i, w, $urandom_range(0, 1));
          else       add_cmd(tgbfs_pkg::MODE_WRITE, i, line, w, $urandom_range(0, 1));
        end
      end
      if ($urandom_range(0, 3) == 0)
        add_cmd(MODE_UNUSED, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                $urandom_range(0, 1), $urandom_range(0, 1));
      add_cmd(tgbfs_pkg::MODE_COMPUTE, $urandom_range(0, ROWS - 1),
              $urandom_range(0, COLS - 1), $urandom_range(0, 1), $urandom_range(0, 1));
      n = $urandom_range(8, 40);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        // Writes after a search change walls but not the distances already held.
        if (pick < 85)
          add_cmd(tgbfs_pkg::MODE_QUERY, $urandom_range(0, ROWS - 1),
                  $urandom_range(0, COLS - 1), $urandom_range(0, 1), $urandom_range(0, 1));
        else if (pick < 95)
          add_cmd(tgbfs_pkg::MODE_WRITE, $urandom_range(0, ROWS - 1),
                  $urandom_range(0, COLS - 1), $urandom_range(0, 1), $urandom_range(0, 1));
        else
          add_cmd(MODE_UNUSED, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end

    // Single reset; the DUT then runs its clearing pass with busy high.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so the check never races the clocked blocks.
    @(negedge clk);
    while (cmd_backlog.size() > 0 || start || expected_dirs.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("** torus_grid_bfs_distance_map: PASSED **");
    end else begin
      $display("** torus_grid_bfs_distance_map: FAILED **");
    end
    $finish;
  end

endmodule
